// ----- sv/acirpe_pkg.sv -----
package acirpe_pkg;

  localparam int FRAME_BYTES = 13;
  localparam int PULSE_COUNT = 2 + FRAME_BYTES * 16 + 2;
  localparam int POS_W = 8;
  localparam int ADDR_W = $clog2(FRAME_BYTES);
  localparam int FILL_W = $clog2(FRAME_BYTES + 1);
  localparam int CFG_IDX_W = 3;
  localparam int DUR_W = 16;

  localparam logic [7:0] SYNC_BYTE = 8'hC3;
  localparam logic [7:0] HSWING_OFF = 8'hE0;
  localparam logic [7:0] LIGHT_OFF = 8'h08;
  localparam logic [7:0] TEMP_MIN = 8'd16;
  localparam logic [7:0] TEMP_MAX = 8'd32;
  localparam logic [7:0] TEMP_OFS = 8'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER_MARK  = 3'd0,
    CFG_HEADER_SPACE = 3'd1,
    CFG_BIT_MARK     = 3'd2,
    CFG_ONE_SPACE    = 3'd3,
    CFG_ZERO_SPACE   = 3'd4,
    CFG_GAP          = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PK_HDR_MARK  = 3'd0,
    PK_HDR_SPACE = 3'd1,
    PK_BIT_MARK  = 3'd2,
    PK_BIT_SPACE = 3'd3,
    PK_GAP       = 3'd4
  } pulse_kind_t;

  typedef struct packed {
    logic [7:0] b1;
    logic [7:0] b4;
    logic [7:0] b6;
    logic [7:0] b9;
    logic [7:0] sum;
  } frame_set_t;

  function automatic logic [2:0] mode_code(input logic [2:0] m);
    logic [2:0] c;
    unique case (m)
      3'd1:    c = 3'b001;
      3'd2:    c = 3'b010;
      3'd3:    c = 3'b100;
      3'd4:    c = 3'b110;
      default: c = 3'b000;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] fan_code(input logic [2:0] f);
    logic [2:0] c;
    unique case (f)
      3'd1:    c = 3'b011;
      3'd2:    c = 3'b010;
      3'd3:    c = 3'b001;
      default: c = 3'b101;
    endcase
    return c;
  endfunction

  function automatic frame_set_t build_set(input logic power, input logic [2:0] ac_mode,
                                           input logic [2:0] fan_speed,
                                           input logic [7:0] temp_c, input logic swing);
    frame_set_t s;
    logic [7:0] t;
    logic [7:0] ofs;
    t = temp_c;
    if (t < TEMP_MIN) t = TEMP_MIN;
    if (t > TEMP_MAX) t = TEMP_MAX;
    ofs = t - TEMP_OFS;
    s.b1 = {ofs[4:0], swing ? 3'b000 : 3'b111};
    s.b4 = {fan_code(fan_speed), 5'd0};
    s.b6 = {mode_code(ac_mode), 5'd0};
    s.b9 = {2'b00, power, 5'd0};
    s.sum = SYNC_BYTE + s.b1 + HSWING_OFF + s.b4 + s.b6 + s.b9 + LIGHT_OFF;
    return s;
  endfunction

  function automatic logic [7:0] frame_byte(input logic [ADDR_W-1:0] idx,
                                            input frame_set_t s);
    logic [7:0] b;
    unique case (idx)
      4'd0:    b = SYNC_BYTE;
      4'd1:    b = s.b1;
      4'd2:    b = HSWING_OFF;
      4'd4:    b = s.b4;
      4'd6:    b = s.b6;
      4'd9:    b = s.b9;
      4'd11:   b = LIGHT_OFF;
      4'd12:   b = s.sum;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

// ----- sv/acirpe_ifs.sv -----
interface acirpe_req_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic       power;
  logic [2:0] ac_mode;
  logic [2:0] fan_speed;
  logic [7:0] temp_c;
  logic       swing;
  modport source (output valid, mode, power, ac_mode, fan_speed, temp_c, swing, input ready);
  modport sink (input valid, mode, power, ac_mode, fan_speed, temp_c, swing, output ready);
endinterface

interface acirpe_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] duration_us;
  logic        is_mark;
  logic        last;
  modport source (output valid, duration_us, is_mark, last, input ready);
  modport sink (input valid, duration_us, is_mark, last, output ready);
endinterface

interface acirpe_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/ac_ir_frame_pulse_encoder_top.sv -----
// A next request's pulse passes the s1 register and the output register before it is
// valid on rsp. Throughput: one request per cycle unless rsp back-pressure or a fill
// stall holds it; a frame memory read is issued as the request is taken. After a load
// the 13 frame bytes are written in the background, one byte a cycle, kept ahead of the
// bit reads by the fill stall. Reset (rst, synchronous): timing registers return to
// defaults, no frame is active, pipeline empties; frame memory contents are kept.
module ac_ir_frame_pulse_encoder_top (
  input logic         clk,
  input logic         rst,
  acirpe_req_if.sink  req,
  acirpe_rsp_if.source rsp,
  acirpe_cfg_if.sink  cfg
);

  localparam int AW = acirpe_pkg::ADDR_W;
  localparam int FW = acirpe_pkg::FILL_W;
  localparam int PW = acirpe_pkg::POS_W;
  localparam int DW = acirpe_pkg::DUR_W;

  logic [DW-1:0] header_mark_us;
  logic [DW-1:0] header_space_us;
  logic [DW-1:0] bit_mark_us;
  logic [DW-1:0] one_space_us;
  logic [DW-1:0] zero_space_us;
  logic [DW-1:0] gap_us;

  logic [7:0] frame_mem [acirpe_pkg::FRAME_BYTES];
  logic [7:0] rd_data;

  logic [PW-1:0]           pos;
  logic                    active;
  logic [FW-1:0]           fill_cnt;
  acirpe_pkg::frame_set_t  fset;

  logic                    s1_valid;
  acirpe_pkg::pulse_kind_t s1_kind;
  logic [2:0]              s1_bit;

  logic          out_valid;
  logic [DW-1:0] out_dur;
  logic          out_mark;
  logic          out_last;

  acirpe_pkg::pulse_kind_t kind;
  logic [PW-1:0]           k;
  logic [AW-1:0]           rd_addr;
  logic                    fill_busy;
  logic                    stall;
  logic                    out_adv;
  logic                    s1_adv;
  logic                    s1_free;
  logic                    acc;
  logic                    acc_load;
  logic                    acc_next;
  logic [DW-1:0]           dur_next;
  logic                    mark_next;
  logic                    last_next;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_mark_us  <= 16'd9166;
      header_space_us <= 16'd4470;
      bit_mark_us     <= 16'd646;
      one_space_us    <= 16'd1647;
      zero_space_us   <= 16'd547;
      gap_us          <= 16'd30000;
    end else if (cfg.valid) begin
      case (cfg.index)
        acirpe_pkg::CFG_HEADER_MARK:  header_mark_us  <= cfg.data;
        acirpe_pkg::CFG_HEADER_SPACE: header_space_us <= cfg.data;
        acirpe_pkg::CFG_BIT_MARK:     bit_mark_us     <= cfg.data;
        acirpe_pkg::CFG_ONE_SPACE:    one_space_us    <= cfg.data;
        acirpe_pkg::CFG_ZERO_SPACE:   zero_space_us   <= cfg.data;
        acirpe_pkg::CFG_GAP:          gap_us          <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    k = pos - PW'(2);
    if (pos == PW'(0)) begin
      kind = acirpe_pkg::PK_HDR_MARK;
    end else if (pos == PW'(1)) begin
      kind = acirpe_pkg::PK_HDR_SPACE;
    end else if (pos < PW'(2 + acirpe_pkg::FRAME_BYTES * 16)) begin
      kind = k[0] ? acirpe_pkg::PK_BIT_SPACE : acirpe_pkg::PK_BIT_MARK;
    end else if (pos == PW'(acirpe_pkg::PULSE_COUNT - 2)) begin
      kind = acirpe_pkg::PK_BIT_MARK;
    end else begin
      kind = acirpe_pkg::PK_GAP;
    end
  end

  assign rd_addr   = k[AW+3:4];
  assign fill_busy = fill_cnt < FW'(acirpe_pkg::FRAME_BYTES);
  assign stall     = req.mode && active && fill_busy &&
                     (kind == acirpe_pkg::PK_BIT_SPACE) && (FW'(rd_addr) >= fill_cnt);

  assign out_adv  = !out_valid || rsp.ready;
  assign s1_adv   = s1_valid && out_adv;
  assign s1_free  = !s1_valid || out_adv;
  assign req.ready = s1_free && !stall;
  assign acc      = req.valid && req.ready;
  assign acc_load = acc && !req.mode;
  assign acc_next = acc && req.mode && active;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      active   <= 1'b0;
      fill_cnt <= FW'(acirpe_pkg::FRAME_BYTES);
    end else if (acc_load) begin
      pos      <= '0;
      active   <= 1'b1;
      fill_cnt <= '0;
    end else begin
      if (acc_next) begin
        if (kind == acirpe_pkg::PK_GAP) begin
          pos    <= '0;
          active <= 1'b0;
        end else begin
          pos <= pos + PW'(1);
        end
      end
      if (fill_busy) begin
        fill_cnt <= fill_cnt + FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_load) begin
      fset <= acirpe_pkg::build_set(req.power, req.ac_mode, req.fan_speed, req.temp_c,
                                    req.swing);
    end
  end

  always_ff @(posedge clk) begin
    if (fill_busy) begin
      frame_mem[fill_cnt[AW-1:0]] <= acirpe_pkg::frame_byte(fill_cnt[AW-1:0], fset);
    end
  end

  always_ff @(posedge clk) begin
    if (acc_next) begin
      rd_data <= frame_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (acc_next) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_next) begin
      s1_kind <= kind;
      s1_bit  <= k[3:1];
    end
  end

  always_comb begin
    dur_next  = '0;
    mark_next = 1'b0;
    last_next = 1'b0;
    unique case (s1_kind)
      acirpe_pkg::PK_HDR_MARK: begin
        dur_next  = header_mark_us;
        mark_next = 1'b1;
      end
      acirpe_pkg::PK_HDR_SPACE: begin
        dur_next = header_space_us;
      end
      acirpe_pkg::PK_BIT_MARK: begin
        dur_next  = bit_mark_us;
        mark_next = 1'b1;
      end
      acirpe_pkg::PK_BIT_SPACE: begin
        dur_next = rd_data[s1_bit] ? one_space_us : zero_space_us;
      end
      acirpe_pkg::PK_GAP: begin
        dur_next  = gap_us;
        last_next = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_dur  <= dur_next;
      out_mark <= mark_next;
      out_last <= last_next;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.duration_us = out_dur;
  assign rsp.is_mark     = out_mark;
  assign rsp.last        = out_last;

  a_fill_ahead: assert property (@(posedge clk) disable iff (rst)
    (acc_next && kind == acirpe_pkg::PK_BIT_SPACE) |-> (!fill_busy || FW'(rd_addr) < fill_cnt))
    else $error("frame byte read before it was written");

  a_gap_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (acc_next && kind == acirpe_pkg::PK_GAP) |=> (!active && pos == '0))
    else $error("frame still active after gap");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos < PW'(acirpe_pkg::PULSE_COUNT))
    else $error("pulse position out of range");

  a_last_is_space: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.last) |-> !rsp.is_mark)
    else $error("gap reported as mark");

endmodule
